/* hw/rtl/ole_pkg.sv */
// Shared types, codes and constants of the ordered list engine.
package ole_pkg;

  // Default number of list entries.
  localparam int unsigned DEPTH_DEFAULT = 16;

  // Operation codes carried in the func field.
  localparam logic [2:0] F_APPEND  = 3'd0;
  localparam logic [2:0] F_PREPEND = 3'd1;
  localparam logic [2:0] F_INSERT  = 3'd2;
  localparam logic [2:0] F_DELAT   = 3'd3;
  localparam logic [2:0] F_DELVAL  = 3'd4;
  localparam logic [2:0] F_SEARCH  = 3'd5;
  localparam logic [2:0] F_LENGTH  = 3'd6;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Found position reported when there is no match.
  localparam logic signed [4:0] NONE_POS = -5'sd1;

  // Commands broadcast to every cell of the chain.
  localparam logic [2:0] CELL_HOLD   = 3'd0;
  localparam logic [2:0] CELL_INSERT = 3'd1;
  localparam logic [2:0] CELL_DELETE = 3'd2;
  localparam logic [2:0] CELL_MARK   = 3'd3;
  localparam logic [2:0] CELL_DROP   = 3'd4;
  localparam logic [2:0] CELL_SKIP   = 3'd5;

  // One input item.
  typedef struct packed {
    logic [2:0]         func;
    logic [4:0]         position;
    logic signed [31:0] item_value;
  } req_t;

  // One result item.
  typedef struct packed {
    logic signed [4:0] found_position;
    logic [4:0]        list_length;
    logic [1:0]        status;
  } rsp_t;

  // Command shared by all cells in a cycle.
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] value;
  } cell_cmd_t;

endpackage

/* hw/rtl/ole_cell.sv */
// One list cell: holds an entry, its match flag and the scan markers.
module ole_cell #(
  parameter int INDEX = 0,
  parameter int PW    = 5
) (
  input  logic                clk,
  input  ole_pkg::cell_cmd_t  cmd,
  input  logic [PW-1:0]       position,
  input  logic [31:0]         left_data,
  input  logic                left_tok,
  input  logic                left_ge,
  input  logic [31:0]         right_data,
  input  logic                right_mflag,
  output logic [31:0]         data,
  output logic                mflag,
  output logic                tok,
  output logic                ge
);

  localparam logic [PW-1:0] IDX = PW'(INDEX);

  // Entries move one place per command; markers walk toward the tail.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      ole_pkg::CELL_INSERT: begin
        if (IDX > position) begin
          data <= left_data;
        end else if (IDX == position) begin
          data <= cmd.value;
        end
      end
      ole_pkg::CELL_DELETE: begin
        if (IDX >= position) begin
          data <= right_data;
        end
      end
      ole_pkg::CELL_MARK: begin
        mflag <= (data == cmd.value);
        tok   <= (IDX == '0);
        ge    <= 1'b1;
      end
      ole_pkg::CELL_DROP: begin
        if (ge) begin
          data  <= right_data;
          mflag <= right_mflag;
        end
      end
      ole_pkg::CELL_SKIP: begin
        tok <= left_tok;
        ge  <= left_ge;
      end
      default: begin
      end
    endcase
  end

endmodule

/* hw/rtl/ordered_list_engine_core.sv */
// Top level of the ordered list engine: control sequencer and the cell chain.
//
// The engine keeps an ordered list of up to DEPTH signed 32-bit words in a
// chain of cells, one entry per cell. Append, prepend, insert, delete at a
// position and length are accepted in the idle state and completed in the
// exec state, in which the cells from the position onward move their entries
// by one place at once; length moves nothing. Search and delete by value
// first mark matching cells in parallel and then walk a scan marker down the
// chain one cell per cycle; each cycle either advances the marker or, for
// delete by value, removes the match under it. One item is in work at a time;
// the next item is accepted while a finished result waits in the output
// register.
module ordered_list_engine_core #(
  parameter int DEPTH = ole_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ole_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ole_pkg::rsp_t rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 5) ? CW : 5;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]          state, state_next;
  ole_pkg::req_t       req_q;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       count0, count0_next;
  logic [CW-1:0]       k, k_next;
  logic                rsp_load;
  ole_pkg::rsp_t       rsp_next;
  logic                out_free;

  logic [PW-1:0]       cnt_x, pos_x, depth_x, ins_pos, len_x, k_x;
  logic                hit, scan_end;

  ole_pkg::cell_cmd_t  cell_cmd;
  logic [PW-1:0]       cell_pos;
  logic [DEPTH-1:0][31:0] cell_data, left_data, right_data;
  logic [DEPTH-1:0]    cell_mflag, cell_tok, cell_ge;
  logic [DEPTH-1:0]    left_tok, left_ge, right_mflag;

  // Handshakes.
  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  // Widened views for comparisons and output fields.
  assign cnt_x    = PW'(count);
  assign pos_x    = PW'(req_q.position);
  assign depth_x  = PW'(DEPTH);
  assign len_x    = PW'(count_next);
  assign k_x      = PW'(k);
  assign hit      = |(cell_tok & cell_mflag);
  assign scan_end = (k == count);

  // Sequencer: decides the cell command and the result of each item.
  always_comb begin
    state_next   = state;
    count_next   = count;
    count0_next  = count0;
    k_next       = k;
    rsp_load     = 1'b0;
    cell_cmd.op    = ole_pkg::CELL_HOLD;
    cell_cmd.value = req_q.item_value;
    cell_pos     = pos_x;
    ins_pos      = pos_x;
    rsp_next.found_position = ole_pkg::NONE_POS;
    rsp_next.status         = ole_pkg::ST_OK;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (req_q.func == ole_pkg::F_DELVAL || req_q.func == ole_pkg::F_SEARCH) begin
          cell_cmd.op = ole_pkg::CELL_MARK;
          k_next      = '0;
          count0_next = count;
          state_next  = S_SCAN;
        end else if (out_free) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
          unique case (req_q.func)
            ole_pkg::F_APPEND, ole_pkg::F_PREPEND, ole_pkg::F_INSERT: begin
              if (req_q.func == ole_pkg::F_APPEND) begin
                ins_pos = cnt_x;
              end else if (req_q.func == ole_pkg::F_PREPEND) begin
                ins_pos = '0;
              end
              if (ins_pos > cnt_x) begin
                rsp_next.status = ole_pkg::ST_RANGE;
              end else if (cnt_x == depth_x) begin
                rsp_next.status = ole_pkg::ST_FULL;
              end else begin
                cell_cmd.op = ole_pkg::CELL_INSERT;
                cell_pos    = ins_pos;
                count_next  = count + CW'(1);
              end
            end
            ole_pkg::F_DELAT: begin
              if (pos_x >= cnt_x) begin
                rsp_next.status = ole_pkg::ST_RANGE;
              end else begin
                cell_cmd.op = ole_pkg::CELL_DELETE;
                count_next  = count - CW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          // Every live entry has been visited.
          if (out_free) begin
            rsp_load   = 1'b1;
            state_next = S_IDLE;
            if (req_q.func == ole_pkg::F_SEARCH || count == count0) begin
              rsp_next.status = ole_pkg::ST_NOTFOUND;
            end
          end
        end else if (hit && req_q.func == ole_pkg::F_SEARCH) begin
          if (out_free) begin
            rsp_load   = 1'b1;
            state_next = S_IDLE;
            rsp_next.found_position = k_x[4:0];
          end
        end else if (hit) begin
          // Remove the match under the marker; the marker stays put.
          cell_cmd.op = ole_pkg::CELL_DROP;
          count_next  = count - CW'(1);
        end else begin
          cell_cmd.op = ole_pkg::CELL_SKIP;
          k_next      = k + CW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    rsp_next.list_length = len_x[4:0];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
    count0 <= count0_next;
    k      <= k_next;
  end

  // Chain of cells with neighbor links.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_data[i] = '0;
      assign left_tok[i]  = 1'b0;
      assign left_ge[i]   = 1'b0;
    end else begin : g_body
      assign left_data[i] = cell_data[i-1];
      assign left_tok[i]  = cell_tok[i-1];
      assign left_ge[i]   = cell_ge[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_data[i]  = cell_data[i];
      assign right_mflag[i] = 1'b0;
    end else begin : g_next
      assign right_data[i]  = cell_data[i+1];
      assign right_mflag[i] = cell_mflag[i+1];
    end

    ole_cell #(
      .INDEX(i),
      .PW   (PW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cell_cmd),
      .position   (cell_pos),
      .left_data  (left_data[i]),
      .left_tok   (left_tok[i]),
      .left_ge    (left_ge[i]),
      .right_data (right_data[i]),
      .right_mflag(right_mflag[i]),
      .data       (cell_data[i]),
      .mflag      (cell_mflag[i]),
      .tok        (cell_tok[i]),
      .ge         (cell_ge[i])
    );
  end

  // The list never holds more entries than there are cells.
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  // The scan marker never passes the end of the list.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> k <= count)
    else $error("scan index past list end");

  // An accepted item always goes to execution next.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> state == S_EXEC)
    else $error("accepted item not executed");

  // Exactly one cell carries the scan marker while the scan is live.
  a_tok_onehot: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && k != count |-> $onehot(cell_tok))
    else $error("scan marker not one-hot");

endmodule
